// File: sv/lcdseq_pkg.sv
`timescale 1ns / 1ps

package lcdseq_pkg;

  localparam int unsigned TICK_W = 20;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SETUP   = 3'd1,
    PH_ELOW    = 3'd2,
    PH_EHIGH   = 3'd3,
    PH_RESLOW  = 3'd4,
    PH_RESWAIT = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_INIT  = 2'd2,
    OP_SPARE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_SETUP      = 3'd0,
    REG_ENABLE_LOW = 3'd1,
    REG_ENABLE_HI  = 3'd2,
    REG_RESET_LOW  = 3'd3,
    REG_RESET_WAIT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]        setup_ticks;
    logic [7:0]        enable_low_ticks;
    logic [15:0]       enable_high_ticks;
    logic [TICK_W-1:0] reset_low_ticks;
    logic [TICK_W-1:0] reset_wait_ticks;
  } cfg_t;

  typedef struct packed {
    phase_t            phase;
    logic [TICK_W-1:0] tick_count;
    logic              init_active;
    logic [7:0]        bus;
    logic              a0;
    logic              cs;
    logic              e;
    logic              res;
  } seq_state_t;

  localparam seq_state_t SEQ_STATE_RST = '{
    phase:       PH_IDLE,
    tick_count:  '0,
    init_active: 1'b0,
    bus:         8'h00,
    a0:          1'b0,
    cs:          1'b0,
    e:           1'b0,
    res:         1'b0
  };

  // Zero programmed ticks behaves as one tick.
  function automatic logic [TICK_W-1:0] phase_ticks(input logic [TICK_W-1:0] ticks);
    phase_ticks = (ticks == '0) ? TICK_W'(1) : ticks;
  endfunction

  // Start-up command table; indexes outside 0 to 13 return 8'hE3.
  function automatic logic [7:0] start_cmd(input logic [3:0] idx);
    logic [7:0] cmd;
    unique case (idx)
      4'd0, 4'd1:   cmd = 8'hE2;
      4'd2, 4'd3:   cmd = 8'hEE;
      4'd4, 4'd5:   cmd = 8'hA4;
      4'd6, 4'd7:   cmd = 8'hA9;
      4'd8, 4'd9:   cmd = 8'hC0;
      4'd10:        cmd = 8'hA1;
      4'd11:        cmd = 8'hA0;
      4'd12, 4'd13: cmd = 8'hAF;
      default:      cmd = 8'hE3;
    endcase
    start_cmd = cmd;
  endfunction

endpackage

// File: sv/lcdseq_cfg.sv
`timescale 1ns / 1ps

module lcdseq_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                we,
  input  logic [2:0]          index,
  input  logic [19:0]         wdata,
  output lcdseq_pkg::cfg_t    cfg
);

  lcdseq_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setup_ticks       <= 8'd1;
      cfg_r.enable_low_ticks  <= 8'd3;
      cfg_r.enable_high_ticks <= 16'd144;
      cfg_r.reset_low_ticks   <= 20'd792;
      cfg_r.reset_wait_ticks  <= 20'd79200;
    end else if (we) begin
      unique case (index)
        lcdseq_pkg::REG_SETUP:      cfg_r.setup_ticks       <= wdata[7:0];
        lcdseq_pkg::REG_ENABLE_LOW: cfg_r.enable_low_ticks  <= wdata[7:0];
        lcdseq_pkg::REG_ENABLE_HI:  cfg_r.enable_high_ticks <= wdata[15:0];
        lcdseq_pkg::REG_RESET_LOW:  cfg_r.reset_low_ticks   <= wdata;
        lcdseq_pkg::REG_RESET_WAIT: cfg_r.reset_wait_ticks  <= wdata;
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: sv/lcdseq_step.sv
`timescale 1ns / 1ps

module lcdseq_step #(
  parameter int unsigned INIT_COMMANDS = 14,
  parameter int unsigned STEP_W        = 4
) (
  input  lcdseq_pkg::seq_state_t state_i,
  input  logic [STEP_W-1:0]      step_i,
  input  lcdseq_pkg::cfg_t       cfg,
  input  lcdseq_pkg::op_t        op,
  input  logic [7:0]             data_byte,
  input  logic                   is_data,
  input  logic                   left_chip,
  output lcdseq_pkg::seq_state_t state_o,
  output logic [STEP_W-1:0]      step_o,
  output logic                   busy,
  output logic                   rejected
);

  logic [4:0] step_ext;

  assign step_ext = 5'(step_i);

  always_comb begin
    state_o  = state_i;
    step_o   = step_i;
    rejected = 1'b0;
    if (state_i.phase != lcdseq_pkg::PH_IDLE) begin
      rejected = (op == lcdseq_pkg::OP_WRITE) || (op == lcdseq_pkg::OP_INIT);
      if (state_i.tick_count > lcdseq_pkg::TICK_W'(1)) begin
        state_o.tick_count = state_i.tick_count - lcdseq_pkg::TICK_W'(1);
      end else begin
        unique case (state_i.phase)
          lcdseq_pkg::PH_SETUP: begin
            state_o.e          = 1'b0;
            state_o.phase      = lcdseq_pkg::PH_ELOW;
            state_o.tick_count = lcdseq_pkg::phase_ticks(
                                   lcdseq_pkg::TICK_W'(cfg.enable_low_ticks));
          end
          lcdseq_pkg::PH_ELOW: begin
            state_o.e          = 1'b1;
            state_o.phase      = lcdseq_pkg::PH_EHIGH;
            state_o.tick_count = lcdseq_pkg::phase_ticks(
                                   lcdseq_pkg::TICK_W'(cfg.enable_high_ticks));
          end
          lcdseq_pkg::PH_RESLOW: begin
            state_o.res        = 1'b1;
            state_o.phase      = lcdseq_pkg::PH_RESWAIT;
            state_o.tick_count = lcdseq_pkg::phase_ticks(cfg.reset_wait_ticks);
          end
          lcdseq_pkg::PH_EHIGH, lcdseq_pkg::PH_RESWAIT: begin
            if (state_i.init_active && (step_ext < 5'(INIT_COMMANDS))) begin
              // Issue the next start-up command, alternating left and right.
              state_o.bus        = lcdseq_pkg::start_cmd(step_ext[3:0]);
              state_o.a0         = 1'b0;
              state_o.cs         = ~step_ext[0];
              state_o.phase      = lcdseq_pkg::PH_SETUP;
              state_o.tick_count = lcdseq_pkg::phase_ticks(
                                     lcdseq_pkg::TICK_W'(cfg.setup_ticks));
              step_o             = STEP_W'(step_ext + 5'd1);
            end else begin
              state_o.init_active = 1'b0;
              state_o.phase       = lcdseq_pkg::PH_IDLE;
              state_o.tick_count  = '0;
            end
          end
          default: begin
            state_o.init_active = 1'b0;
            state_o.phase       = lcdseq_pkg::PH_IDLE;
            state_o.tick_count  = '0;
          end
        endcase
      end
    end else if (op == lcdseq_pkg::OP_WRITE) begin
      state_o.bus        = data_byte;
      state_o.a0         = is_data;
      state_o.cs         = left_chip;
      state_o.phase      = lcdseq_pkg::PH_SETUP;
      state_o.tick_count = lcdseq_pkg::phase_ticks(lcdseq_pkg::TICK_W'(cfg.setup_ticks));
    end else if (op == lcdseq_pkg::OP_INIT) begin
      state_o.e           = 1'b1;
      state_o.res         = 1'b0;
      state_o.init_active = 1'b1;
      step_o              = '0;
      state_o.phase       = lcdseq_pkg::PH_RESLOW;
      state_o.tick_count  = lcdseq_pkg::phase_ticks(cfg.reset_low_ticks);
    end
  end

  assign busy = (state_o.phase != lcdseq_pkg::PH_IDLE);

endmodule

// File: sv/lcd_parallel_bus_write_sequencer_unit.sv
`timescale 1ns / 1ps

// Pin-level write sequencer for a dual-controller graphic LCD on an 8-bit bus.
// Each input beat is one timing tick; in_tuser carries the op (plain tick,
// byte-write request or init request) with the A0 and CS levels for a write,
// and in_tdata holds the byte. Every input beat yields exactly one output beat
// carrying the pin levels (bus, A0, CS, E, RES) after that tick, the busy flag
// and a flag that marks a request ignored because a sequence was still running.
// Phase lengths come from the cfg_ write port, which the user must write only
// while the block is idle, which the block itself does not enforce; an unmapped index is dropped.
// A beat accepted into the input register moves into the result register once
// that slot is free and is then offered at the output (one input register, one
// result register). Throughput: one beat per cycle while the receiver does not
// stall, set by the combinational sequencer update between the two registers.
// Reset clears the sequencer to idle with every pin latch low and loads the
// default phase lengths. When the receiver stalls, the result register holds
// and the input register fills; in_tready falls only when both are full.
module lcd_parallel_bus_write_sequencer_unit #(
  parameter int unsigned INIT_COMMANDS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte[7:0]
  input  logic [3:0]  in_tuser,   // op[1:0], is_data[2], left_chip[3]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // bus_byte[7:0], a0_pin[8], cs_pin[9], e_pin[10],
                                  // res_pin[11], busy_res[12], rejected[13], zero pad
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_wdata
);

  localparam int unsigned STEP_W = $clog2(INIT_COMMANDS + 1);

  lcdseq_pkg::cfg_t       cfg;
  lcdseq_pkg::seq_state_t state_r, state_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;

  // Input register.
  logic              in_valid_r;
  lcdseq_pkg::op_t   in_op_r;
  logic [7:0]        in_byte_r;
  logic              in_a0_r;
  logic              in_cs_r;

  // Result register.
  logic              out_valid_r;
  logic [15:0]       out_data_r;

  logic              busy;
  logic              rejected;
  logic              advance;

  // Move the held beat into the result register when that slot is free.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  lcdseq_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  lcdseq_step #(
    .INIT_COMMANDS (INIT_COMMANDS),
    .STEP_W        (STEP_W)
  ) u_step (
    .state_i   (state_r),
    .step_i    (step_r),
    .cfg       (cfg),
    .op        (in_op_r),
    .data_byte (in_byte_r),
    .is_data   (in_a0_r),
    .left_chip (in_cs_r),
    .state_o   (state_nxt),
    .step_o    (step_nxt),
    .busy      (busy),
    .rejected  (rejected)
  );

  // Capture an accepted beat; drop the valid once it has advanced.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_op_r   <= lcdseq_pkg::op_t'(in_tuser[1:0]);
      in_byte_r <= in_tdata;
      in_a0_r   <= in_tuser[2];
      in_cs_r   <= in_tuser[3];
    end
  end

  // Advance the sequencer exactly once per beat, as it enters the result slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lcdseq_pkg::SEQ_STATE_RST;
      step_r  <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {2'b00, rejected, busy, state_nxt.res, state_nxt.e,
                     state_nxt.cs, state_nxt.a0, state_nxt.bus};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
